>>> sv/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared sizes, codes and helper functions for the register file ALU executor.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int NUM_REGS   = 26;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the channels
    localparam int MODE_W = 4;
    localparam int IDX_W  = 5;
    localparam int IMM_W  = 32;
    localparam int OUT_W  = 32;

    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int REG_SLOTS = 1 << REG_AW;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_PW    = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam int DIV_CW = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 4'd0,
        MODE_OUT  = 4'd1,
        MODE_MOVE = 4'd2,
        MODE_XCHG = 4'd3,
        MODE_ADD  = 4'd4,
        MODE_SUB  = 4'd5,
        MODE_MUL  = 4'd6,
        MODE_DIV  = 4'd7,
        MODE_MOD  = 4'd8,
        MODE_AND  = 4'd9,
        MODE_OR   = 4'd10,
        MODE_XOR  = 4'd11
    } mode_t;

    typedef enum logic [2:0] {
        K_LOAD,
        K_OUT,
        K_MOVE,
        K_XCHG,
        K_ALU
    } kind_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD,
        ALU_AND,
        ALU_OR,
        ALU_XOR
    } alu_op_t;

    // decoded instruction as queued between front and back
    typedef struct packed {
        kind_t            kind;
        alu_op_t          alu;
        logic [IDX_W-1:0] x_idx;
        logic             x_ok;
        logic [IDX_W-1:0] y_idx;
        logic             y_ok;
        logic [IDX_W-1:0] wr_idx;
        logic             wr_ok;
        logic [IDX_W-1:0] wr2_idx;
        logic             wr2_ok;
        data_t            imm;
    } cmd_t;

    typedef struct packed {
        logic  start;
        data_t dividend;
        data_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        data_t quo;
        data_t rem;
    } div_rsp_t;

    function automatic logic in_range(logic [IDX_W-1:0] idx);
        return int'(idx) < NUM_REGS;
    endfunction

    function automatic data_t imm_to_data(logic [IMM_W-1:0] imm);
        logic [DATA_WIDTH+IMM_W-1:0] ext;
        ext = {{DATA_WIDTH{imm[IMM_W-1]}}, imm};
        return ext[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] data_to_out(data_t d);
        logic [DATA_WIDTH+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, d};
        return ext[OUT_W-1:0];
    endfunction

    // magnitude of a two's complement word, most negative value stays as 2^(w-1)
    function automatic data_t mag(data_t v);
        return v[DATA_WIDTH-1] ? data_t'(-v) : v;
    endfunction

endpackage

>>> sv/rfa_if.sv
// ----------------------------------------------------------------------------
// rfa_cmd_if / rfa_res_if
// Valid/ready channels for instruction beats in and result beats out.
// ----------------------------------------------------------------------------
interface rfa_cmd_if
    import rfa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [IDX_W-1:0]         dest_reg;
    logic [IDX_W-1:0]         src_a_reg;
    logic [IDX_W-1:0]         src_b_reg;
    logic signed [IMM_W-1:0]  immediate;
    logic                     three_operand;

    modport source (
        output valid, mode, dest_reg, src_a_reg, src_b_reg, immediate, three_operand,
        input  ready
    );
    modport sink (
        input  valid, mode, dest_reg, src_a_reg, src_b_reg, immediate, three_operand,
        output ready
    );
endinterface

interface rfa_res_if
    import rfa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  out_value;
    logic                     div_error;

    modport source (
        output valid, out_value, div_error,
        input  ready
    );
    modport sink (
        input  valid, out_value, div_error,
        output ready
    );
endinterface

>>> sv/rfa_ram.sv
// ----------------------------------------------------------------------------
// rfa_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    output logic [WIDTH-1:0] rdata0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> sv/rfa_front.sv
// ----------------------------------------------------------------------------
// rfa_front
// Takes instruction beats, decodes them and pushes them onto the queue.
// ----------------------------------------------------------------------------
module rfa_front
    import rfa_pkg::*;
(
    rfa_cmd_if.sink cmd,
    input  logic    full,
    output logic    push,
    output cmd_t    push_data
);

    cmd_t c;
    logic keep;

    always_comb
    begin
        c        = '0;
        c.kind   = K_LOAD;
        c.alu    = ALU_ADD;
        keep     = 1'b1;
        c.wr_idx = cmd.dest_reg;
        if (cmd.three_operand)
        begin
            c.x_idx = cmd.src_a_reg;
            c.y_idx = cmd.src_b_reg;
        end
        else
        begin
            c.x_idx = cmd.dest_reg;
            c.y_idx = cmd.src_a_reg;
        end
        unique case (mode_t'(cmd.mode))
            MODE_LOAD:
            begin
                c.kind = K_LOAD;
                c.imm  = imm_to_data(cmd.immediate);
            end
            MODE_OUT:
            begin
                c.kind  = K_OUT;
                c.x_idx = cmd.dest_reg;
            end
            MODE_MOVE:
            begin
                c.kind  = K_MOVE;
                c.x_idx = cmd.src_a_reg;
            end
            MODE_XCHG:
            begin
                c.kind    = K_XCHG;
                c.x_idx   = cmd.dest_reg;
                c.y_idx   = cmd.src_a_reg;
                c.wr2_idx = cmd.src_a_reg;
            end
            MODE_ADD: begin c.kind = K_ALU; c.alu = ALU_ADD; end
            MODE_SUB: begin c.kind = K_ALU; c.alu = ALU_SUB; end
            MODE_MUL: begin c.kind = K_ALU; c.alu = ALU_MUL; end
            MODE_DIV: begin c.kind = K_ALU; c.alu = ALU_DIV; end
            MODE_MOD: begin c.kind = K_ALU; c.alu = ALU_MOD; end
            MODE_AND: begin c.kind = K_ALU; c.alu = ALU_AND; end
            MODE_OR:  begin c.kind = K_ALU; c.alu = ALU_OR;  end
            MODE_XOR: begin c.kind = K_ALU; c.alu = ALU_XOR; end
            // unused modes are taken and dropped
            default:  keep = 1'b0;
        endcase
        c.x_ok   = in_range(c.x_idx);
        c.y_ok   = in_range(c.y_idx);
        c.wr_ok  = in_range(c.wr_idx);
        c.wr2_ok = in_range(c.wr2_idx);
    end

    assign cmd.ready = !full;
    assign push      = cmd.valid && !full && keep;
    assign push_data = c;

endmodule

>>> sv/rfa_fifo.sv
// ----------------------------------------------------------------------------
// rfa_fifo
// Short queue of decoded instructions between front and back.
// ----------------------------------------------------------------------------
module rfa_fifo
    import rfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic head_valid
);

    cmd_t             fq_reg [FQ_DEPTH];
    logic [FQ_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0] count_reg, count_next;

    function automatic logic [FQ_PW-1:0] bump(logic [FQ_PW-1:0] p);
        return (int'(p) == FQ_DEPTH - 1) ? '0 : FQ_PW'(p + 1'b1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = FQ_CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = FQ_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = int'(count_reg) == FQ_DEPTH;
    assign head_valid = count_reg != '0;
    assign head       = fq_reg[rd_ptr_reg];

endmodule

>>> sv/rfa_div.sv
// ----------------------------------------------------------------------------
// rfa_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// signs applied on the way out (quotient truncates, remainder follows dividend).
// ----------------------------------------------------------------------------
module rfa_div
    import rfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    data_t             rem_reg, rem_next;
    data_t             quo_reg, quo_next;
    data_t             dvs_reg, dvs_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;

    logic [DATA_WIDTH:0] sh_rem;
    logic [DATA_WIDTH:0] diff;
    logic                ge;

    always_comb
    begin
        sh_rem = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff   = sh_rem - {1'b0, dvs_reg};
        ge     = !diff[DATA_WIDTH];

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = DIV_CW'(DATA_WIDTH);
            rem_next   = '0;
            quo_next   = mag(req.dividend);
            dvs_next   = mag(req.divisor);
            neg_q_next = req.dividend[DATA_WIDTH-1] ^ req.divisor[DATA_WIDTH-1];
            neg_r_next = req.dividend[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DATA_WIDTH-1:0] : sh_rem[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], ge};
            cnt_next = DIV_CW'(cnt_reg - 1'b1);
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dvs_reg   <= '0;
            neg_q_reg <= 1'b0;
            neg_r_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            dvs_reg   <= dvs_next;
            neg_q_reg <= neg_q_next;
            neg_r_reg <= neg_r_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_q_reg ? data_t'(-quo_reg) : quo_reg;
    assign rsp.rem  = neg_r_reg ? data_t'(-rem_reg) : rem_reg;

endmodule

>>> sv/rfa_back.sv
// ----------------------------------------------------------------------------
// rfa_back
// Pops decoded instructions, reads the register file, executes and writes
// back; holds the result register of the output channel.
// ----------------------------------------------------------------------------
module rfa_back
    import rfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  logic      head_valid,
    output logic      pop,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp,
    rfa_res_if.source res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_SWAP
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    data_t                hold_reg, hold_next;
    logic [REG_SLOTS-1:0] valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_value_reg, out_value_next;
    logic                 div_error_reg, div_error_next;

    logic [REG_AW-1:0] raddr_x, raddr_y, waddr;
    logic              we, wok, ram_we;
    data_t             wdata, q_x, q_y, x_val, y_val, alu_res;
    logic              out_free;

    rfa_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr_x),
        .rdata0 (q_x),
        .raddr1 (raddr_y),
        .rdata1 (q_y)
    );

    // read the queue head while idle so operands land as execute starts
    assign raddr_x = (state_reg == S_IDLE) ? head.x_idx[REG_AW-1:0] : cmd_reg.x_idx[REG_AW-1:0];
    assign raddr_y = (state_reg == S_IDLE) ? head.y_idx[REG_AW-1:0] : cmd_reg.y_idx[REG_AW-1:0];

    // registers never written since reset read as zero
    assign x_val = (cmd_reg.x_ok && valid_reg[cmd_reg.x_idx[REG_AW-1:0]]) ? q_x : '0;
    assign y_val = (cmd_reg.y_ok && valid_reg[cmd_reg.y_idx[REG_AW-1:0]]) ? q_y : '0;

    always_comb
    begin
        unique case (cmd_reg.alu)
            ALU_ADD: alu_res = data_t'(x_val + y_val);
            ALU_SUB: alu_res = data_t'(x_val - y_val);
            ALU_MUL: alu_res = data_t'(x_val * y_val);
            ALU_AND: alu_res = x_val & y_val;
            ALU_OR:  alu_res = x_val | y_val;
            ALU_XOR: alu_res = x_val ^ y_val;
            ALU_DIV,
            ALU_MOD: alu_res = '0;
        endcase
    end

    assign out_free = !out_valid_reg || res.ready;
    assign ram_we   = we && wok;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        hold_next      = hold_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_value_next = out_value_reg;
        div_error_next = div_error_reg;
        pop            = 1'b0;
        we             = 1'b0;
        wok            = cmd_reg.wr_ok;
        waddr          = cmd_reg.wr_idx[REG_AW-1:0];
        wdata          = alu_res;
        div_req.start    = 1'b0;
        div_req.dividend = x_val;
        div_req.divisor  = y_val;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg.kind)
                    K_LOAD:
                    begin
                        we         = 1'b1;
                        wdata      = cmd_reg.imm;
                        state_next = S_IDLE;
                    end
                    K_OUT:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = data_to_out(x_val);
                            div_error_next = 1'b0;
                            state_next     = S_IDLE;
                        end
                    end
                    K_MOVE:
                    begin
                        we         = 1'b1;
                        wdata      = x_val;
                        state_next = S_IDLE;
                    end
                    K_XCHG:
                    begin
                        we         = 1'b1;
                        wdata      = y_val;
                        hold_next  = x_val;
                        state_next = S_SWAP;
                    end
                    K_ALU:
                    begin
                        if (cmd_reg.alu == ALU_DIV || cmd_reg.alu == ALU_MOD)
                        begin
                            if (y_val == '0)
                            begin
                                // refused, registers untouched
                                if (out_free)
                                begin
                                    out_valid_next = 1'b1;
                                    out_value_next = '0;
                                    div_error_next = 1'b1;
                                    state_next     = S_IDLE;
                                end
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                        else
                        begin
                            we         = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    we         = 1'b1;
                    wdata      = (cmd_reg.alu == ALU_DIV) ? div_rsp.quo : div_rsp.rem;
                    state_next = S_IDLE;
                end
            end
            S_SWAP:
            begin
                we         = 1'b1;
                wok        = cmd_reg.wr2_ok;
                waddr      = cmd_reg.wr2_idx[REG_AW-1:0];
                wdata      = hold_reg;
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            hold_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            div_error_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            hold_reg      <= hold_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            div_error_reg <= div_error_next;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_value = out_value_reg;
    assign res.div_error = div_error_reg;

endmodule

>>> sv/register_file_alu_executor.sv
// ----------------------------------------------------------------------------
// register_file_alu_executor
// Runs decoded instructions against a file of signed registers.
// ----------------------------------------------------------------------------
// Each beat on cmd is one decoded instruction; a beat on res comes back only
// for an output instruction or a refused divide/modulo by zero. The front end
// takes a beat whenever its two-entry queue has room, so it keeps accepting
// while the back end works or while a result waits on res. The back end runs
// one instruction at a time: load, output, move and the non-dividing ALU
// operations take a register file read, then execute and write back,
// exchange takes a second write step because the file has a single write
// port, and divide or modulo wait on the radix-2 divider producing one
// quotient bit per cycle. The register file is zero straight after reset
// through per-register valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module register_file_alu_executor
    import rfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rfa_cmd_if.sink   cmd,
    rfa_res_if.source res
);

    logic     push, full, pop, head_valid;
    cmd_t     push_data, head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    rfa_front u_front (
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    rfa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    rfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .res        (res)
    );

endmodule

>>> sv/rfa_checker.sv
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks on the register file ALU executor, bound to the top.
// ----------------------------------------------------------------------------
module rfa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [31:0] res_out_value,
    input logic               res_div_error
);

    // a result beat waiting on the sink keeps its contents
    ap_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_out_value)
            && $stable(res_div_error))
        else $error("result beat changed while stalled");

    // a refused divide always reports a zero value
    ap_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_div_error |-> res_out_value == 32'sd0)
        else $error("divide error beat with non-zero value");

    // nothing comes out while held in reset
    ap_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result beat during reset");

    // the front end takes beats straight after reset, the queue being empty
    ap_ready_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> cmd_ready)
        else $error("front end not ready after reset");

endmodule

bind register_file_alu_executor rfa_checker u_rfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_out_value (res.out_value),
    .res_div_error (res.div_error)
);

>>> test/rfa_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfa_result_checker
// Watches the instruction and result channels of the register file ALU
// executor. Each accepted instruction is run against a private copy of the
// register file. Every result beat is compared field by field with the oldest
// result still awaited.
// ----------------------------------------------------------------------------
module rfa_result_checker
    import rfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rfa_cmd_if   cmd,
    rfa_res_if   res,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             div_error;
    } result_t;

    data_t   shadow_regs [NUM_REGS];
    result_t awaited_results [$];
    int      error_count;

    // indexes past the end of the file read as zero
    function automatic data_t read_reg(logic [IDX_W-1:0] idx);
        if (idx < NUM_REGS)
            return shadow_regs[idx];
        return '0;
    endfunction

    function automatic void write_reg(logic [IDX_W-1:0] idx, data_t value);
        if (idx < NUM_REGS)
            shadow_regs[idx] = value;
    endfunction

    // y is never zero for divide or modulo here
    function automatic data_t alu_result(logic [MODE_W-1:0] op, data_t x, data_t y);
        data_t abs_x;
        data_t abs_y;
        abs_x = x[DATA_WIDTH-1] ? -x : x;
        abs_y = y[DATA_WIDTH-1] ? -y : y;
        case (op)
            MODE_ADD: return x + y;
            MODE_SUB: return x - y;
            MODE_MUL: return x * y;
            MODE_DIV:
            begin
                // truncation toward zero, most negative over minus one wraps
                if (x[DATA_WIDTH-1] != y[DATA_WIDTH-1])
                    return -(abs_x / abs_y);
                return abs_x / abs_y;
            end
            MODE_MOD:
            begin
                // remainder follows the sign of the dividend
                if (x[DATA_WIDTH-1])
                    return -(abs_x % abs_y);
                return abs_x % abs_y;
            end
            MODE_AND: return x & y;
            MODE_OR:  return x | y;
            default:  return x ^ y;
        endcase
    endfunction

    function automatic void execute_instr(logic [MODE_W-1:0] op, logic [IDX_W-1:0] d,
                                          logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                          logic [IMM_W-1:0] imm, logic three);
        data_t x;
        data_t y;
        data_t held;
        case (op)
            MODE_LOAD: write_reg(d, data_t'(signed'(imm)));
            MODE_OUT:  awaited_results.push_back('{value: OUT_W'(read_reg(d)), div_error: 1'b0});
            MODE_MOVE: write_reg(d, read_reg(a));
            MODE_XCHG:
            begin
                held = read_reg(d);
                write_reg(d, read_reg(a));
                write_reg(a, held);
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_AND, MODE_OR, MODE_XOR:
            begin
                if (three)
                begin
                    x = read_reg(a);
                    y = read_reg(b);
                end
                else
                begin
                    x = read_reg(d);
                    y = read_reg(a);
                end
                // refused divide: file untouched, error beat instead
                if ((op == MODE_DIV || op == MODE_MOD) && y == '0)
                    awaited_results.push_back('{value: '0, div_error: 1'b1});
                else
                    write_reg(d, alu_result(op, x, y));
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            foreach (shadow_regs[i])
                shadow_regs[i] = '0;
            awaited_results.delete();
            error_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                execute_instr(cmd.mode, cmd.dest_reg, cmd.src_a_reg, cmd.src_b_reg,
                              cmd.immediate, cmd.three_operand);
            if (res.valid && res.ready)
            begin
                got = '{value: res.out_value, div_error: res.div_error};
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result beat expected none, got out_value %0d div_error %0b",
                             $time, $signed(got.value), got.div_error);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.value != want.value)
                    begin
                        error_count++;
                        $display("%0t: out_value expected %0d, got %0d",
                                 $time, $signed(want.value), $signed(got.value));
                    end
                    if (got.div_error != want.div_error)
                    begin
                        error_count++;
                        $display("%0t: div_error expected %0b, got %0b",
                                 $time, want.div_error, got.div_error);
                    end
                end
            end
            errors  <= error_count;
            pending <= awaited_results.size();
        end
    end

endmodule

>>> test/tb_register_file_alu_executor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_file_alu_executor
// Drives instruction beats into the executor: a directed opening over the
// extremes, every operation and the corner cases, then random programmes.
// Both channels idle at random; the checker beside the block does the
// prediction and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_register_file_alu_executor;
    import rfa_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 3 * (DATA_WIDTH + 3) + 16;
    localparam int RANDOM_ITEMS = 410;
    localparam int IDLE_PCT     = 11;
    localparam int MAX_IDX      = (1 << IDX_W) - 1;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd12;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

    localparam logic [IMM_W-1:0] IMM_MIN = {1'b1, {(IMM_W-1){1'b0}}};
    localparam logic [IMM_W-1:0] IMM_MAX = {1'b0, {(IMM_W-1){1'b1}}};
    localparam logic [IMM_W-1:0] IMM_ONES = '1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  dest;
        logic [IDX_W-1:0]  src_a;
        logic [IDX_W-1:0]  src_b;
        logic [IMM_W-1:0]  imm;
        logic              three;
    } instr_t;

    logic clk;
    logic rst_n;
    logic calm;
    int   errors;
    int   pending;
    int   sent;

    rfa_cmd_if cmd ();
    rfa_res_if res ();

    register_file_alu_executor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    rfa_result_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        res.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic instr_t make_instr(logic [MODE_W-1:0] op, int d, int a, int b,
                                          logic [IMM_W-1:0] imm, logic three);
        instr_t beat;
        beat.mode  = op;
        beat.dest  = IDX_W'(d);
        beat.src_a = IDX_W'(a);
        beat.src_b = IDX_W'(b);
        beat.imm   = imm;
        beat.three = three;
        return beat;
    endfunction

    // mostly live registers, now and then an index past the end of the file
    function automatic logic [IDX_W-1:0] random_idx();
        if ($urandom_range(0, 99) < 6)
            return IDX_W'($urandom_range(NUM_REGS, MAX_IDX));
        return IDX_W'($urandom_range(0, NUM_REGS - 1));
    endfunction

    function automatic instr_t random_instr();
        instr_t beat;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            beat.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        else if (pick < 18)
            beat.mode = MODE_LOAD;
        else if (pick < 36)
            beat.mode = MODE_OUT;
        else if (pick < 43)
            beat.mode = MODE_MOVE;
        else if (pick < 49)
            beat.mode = MODE_XCHG;
        else if (pick < 59)
            beat.mode = MODE_DIV;
        else if (pick < 67)
            beat.mode = MODE_MOD;
        else
            beat.mode = MODE_W'($urandom_range(MODE_ADD, MODE_XOR));
        beat.dest  = random_idx();
        beat.src_a = random_idx();
        beat.src_b = random_idx();
        beat.three = 1'($urandom_range(0, 1));
        // small values keep zero divisors and signed corners coming
        case ($urandom_range(0, 3))
            0: beat.imm = $urandom();
            1: beat.imm = IMM_W'($urandom_range(0, 16) - 8);
            2: beat.imm = IMM_W'($urandom_range(0, 1000));
            default:
            begin
                case ($urandom_range(0, 4))
                    0: beat.imm = IMM_MIN;
                    1: beat.imm = IMM_MAX;
                    2: beat.imm = IMM_ONES;
                    3: beat.imm = IMM_W'(1);
                    default: beat.imm = '0;
                endcase
            end
        endcase
        return beat;
    endfunction

    task automatic send_instr(input instr_t beat);
        calm = (sent >= 260 && sent < 380);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.mode          <= beat.mode;
        cmd.dest_reg      <= beat.dest;
        cmd.src_a_reg     <= beat.src_a;
        cmd.src_b_reg     <= beat.src_b;
        cmd.immediate     <= beat.imm;
        cmd.three_operand <= beat.three;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
    endtask

    // let the checker take in the last beat before looking at pending
    task automatic wait_for_results();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        instr_t beat;
        int     counted;
        rst_n             <= 1'b0;
        cmd.valid         <= 1'b0;
        cmd.mode          <= '0;
        cmd.dest_reg      <= '0;
        cmd.src_a_reg     <= '0;
        cmd.src_b_reg     <= '0;
        cmd.immediate     <= '0;
        cmd.three_operand <= 1'b0;
        sent = 0;
        calm = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_instr(make_instr(MODE_LOAD, 0, 0, 0, IMM_MAX, 1'b0));
        send_instr(make_instr(MODE_LOAD, 1, 0, 0, IMM_MIN, 1'b0));
        send_instr(make_instr(MODE_LOAD, 2, 0, 0, IMM_ONES, 1'b0));
        // writes past the file are dropped and such reads give zero
        send_instr(make_instr(MODE_LOAD, MAX_IDX, 0, 0, 123, 1'b0));
        send_instr(make_instr(MODE_OUT, MAX_IDX, 0, 0, '0, 1'b0));
        send_instr(make_instr(MODE_OUT, 1, 0, 0, '0, 1'b0));
        send_instr(make_instr(MODE_ADD, 3, 0, 0, '0, 1'b1));
        send_instr(make_instr(MODE_SUB, 4, 1, 0, '0, 1'b1));
        send_instr(make_instr(MODE_MUL, 5, 0, 1, '0, 1'b1));
        // most negative over minus one
        send_instr(make_instr(MODE_DIV, 6, 1, 2, '0, 1'b1));
        send_instr(make_instr(MODE_MOD, 7, 1, 2, '0, 1'b1));
        // zero divisors in both forms
        send_instr(make_instr(MODE_DIV, 8, 0, 9, '0, 1'b1));
        send_instr(make_instr(MODE_MOD, 0, 10, 0, '0, 1'b0));
        send_instr(make_instr(MODE_DIV, 11, 1, 3, '0, 1'b1));
        send_instr(make_instr(MODE_MOD, 12, 2, 0, '0, 1'b1));
        send_instr(make_instr(MODE_AND, 13, 0, 2, '0, 1'b1));
        send_instr(make_instr(MODE_OR, 13, 1, 0, '0, 1'b0));
        send_instr(make_instr(MODE_XOR, 14, 2, 0, '0, 1'b1));
        send_instr(make_instr(MODE_MOVE, 15, 1, 0, '0, 1'b0));
        send_instr(make_instr(MODE_MOVE, 16, MAX_IDX - 1, 0, '0, 1'b0));
        send_instr(make_instr(MODE_XCHG, 15, 0, 0, '0, 1'b0));
        send_instr(make_instr(MODE_XCHG, 5, 5, 0, '0, 1'b0));
        send_instr(make_instr(MODE_XCHG, NUM_REGS - 1, MAX_IDX - 2, 0, '0, 1'b0));
        send_instr(make_instr(MODE_UNUSED_LO, 0, 0, 0, IMM_ONES, 1'b1));
        send_instr(make_instr(MODE_UNUSED_HI, MAX_IDX, MAX_IDX, MAX_IDX, IMM_ONES, 1'b1));
        send_instr(make_instr(MODE_OUT, 15, 0, 0, '0, 1'b0));
        send_instr(make_instr(MODE_OUT, 0, 0, 0, '0, 1'b0));

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            beat = random_instr();
            if (beat.mode <= MODE_XOR)
                counted++;
            send_instr(beat);
            // hold off once until the executor has answered everything
            if (sent == 170)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
